[rtl/zts_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zts_pkg: shared types and constants for the z-buffered triangle shader
// Frame size, request codes, register indexes and the word types of the
// command and result channels.
// ---------------------------------------------------------------------------
package zts_pkg;

	localparam int FRAME_WIDTH  = 64;
	localparam int FRAME_HEIGHT = 64;
	localparam int NPIX         = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int PIX_AW       = $clog2(NPIX);
	localparam int COL_W        = $clog2(FRAME_WIDTH);
	localparam int ROW_W        = $clog2(FRAME_HEIGHT);

	localparam logic REQ_VERTEX = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	localparam logic [1:0] REG_LIGHT_X = 2'd0;
	localparam logic [1:0] REG_LIGHT_Y = 2'd1;
	localparam logic [1:0] REG_LIGHT_Z = 2'd2;

	localparam logic signed [15:0] LIGHT_X_RST = -16'sd9459;
	localparam logic signed [15:0] LIGHT_Y_RST = 16'sd9459;
	localparam logic signed [15:0] LIGHT_Z_RST = -16'sd9459;
	localparam logic signed [15:0] DEPTH_RST   = -16'sd32768;
	localparam logic [12:0]        COUNT_MAX   = 13'd8191;

	typedef struct packed {
		logic              req_type;
		logic signed [15:0] vert_x;
		logic signed [15:0] vert_y;
		logic signed [15:0] vert_depth;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic [5:0]        read_col;
		logic [5:0]        read_row;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0]         pixel_shade;
		logic signed [15:0] pixel_depth;
		logic               triangle_done;
		logic [12:0]        pixels_written;
	} res_word_t;

endpackage

[rtl/zbuffer_triangle_shader_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// zbuffer_triangle_shader_core: z-buffered Gouraud-normal gray rasterizer
// Collects three vertices, walks the clamped bounding box and writes depth
// and shade for covered pixels that pass the depth test. Read commands
// return one stored pixel.
// ---------------------------------------------------------------------------
//
//  channel | signals                      | handshake
//  --------+------------------------------+-------------------------------
//  command | start, busy, cmd             | taken when start && !busy
//  result  | done, res                    | one-cycle strobe, no stall
//  config  | cfg_we, cfg_idx, cfg_data    | written when cfg_we is high
//
// A vertex other than the third returns to idle through S_READ2, a read through
// S_READ and S_READ2. A degenerate third vertex ends in S_FIN after setup; any other
// runs setup and S_BOX, then for each pixel of the bounding box the edge products,
// with depth and z-test if covered and normals and shade if drawn, then S_FIN.
// Each of the four interpolated values costs a multiply-accumulate over the
// vertices, 56 restoring-division steps and a final rounding on the shared unit.
// After reset the block sweeps both stores, one pixel a cycle, with busy
// high. Configuration writes are taken at any time.
// The result receiver cannot stall; results appear for one cycle.
module zbuffer_triangle_shader_core
	import zts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_word_t   cmd,
	output logic        done,
	output res_word_t   res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_READ, S_READ2, S_SETUP0, S_SETUP1, S_SETUP2, S_BOX,
		S_PIX0, S_PIX1, S_PIX2, S_PIX3, S_MIXM, S_DIV, S_DIVEND, S_ZTEST,
		S_DOT, S_SHADE, S_NEXT, S_FIN
	} state_t;

	state_t state_q;

	// store memories
	logic signed [15:0] depth_mem [NPIX];
	logic [7:0]         shade_mem [NPIX];
	logic               mem_we;
	logic [PIX_AW-1:0]  mem_waddr, mem_raddr;
	logic signed [15:0] mem_wdepth, depth_rd_q;
	logic [7:0]         mem_wshade, shade_rd_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			depth_mem[mem_waddr] <= mem_wdepth;
			shade_mem[mem_waddr] <= mem_wshade;
		end
		depth_rd_q <= depth_mem[mem_raddr];
		shade_rd_q <= shade_mem[mem_raddr];
	end

	logic signed [15:0] light_x_q, light_y_q, light_z_q;
	logic signed [15:0] vx_q [3], vy_q [3], vz_q [3], nx_q [3], ny_q [3], nz_q [3];
	logic [1:0]  vcnt_q;
	logic [PIX_AW-1:0] clr_q;
	logic signed [17:0] abx_q, aby_q, acx_q, acy_q;
	logic signed [36:0] d_q;
	logic        neg_q;
	logic [COL_W-1:0] x1_q, px_q;
	logic [ROW_W-1:0] y0_q, y1_q, py_q;
	logic signed [17:0] apx_q, apy_q;
	logic signed [37:0] t1_q, nb_q, nc_q, na_q;
	logic [1:0]  comp_q;
	logic [1:0]  term_q;
	logic signed [55:0] acc_q;
	logic [55:0] rem_q;
	logic [55:0] quo_q;
	logic [5:0]  step_q;
	logic        qneg_q;
	logic signed [15:0] zval_q;
	logic signed [15:0] n_q [3];
	logic signed [35:0] dot_q;
	logic [12:0] count_q;
	logic [1:0]  mterm_q;

	// shared multiplier: one 18x38 signed product per cycle
	logic signed [17:0] mul_a;
	logic signed [37:0] mul_b;
	logic signed [55:0] mul_p;
	assign mul_p = 56'(mul_a * mul_b);

	logic signed [15:0] csel [3];
	always_comb begin
		case (comp_q)
			2'd0:    for (int i = 0; i < 3; i++) csel[i] = vz_q[i];
			2'd1:    for (int i = 0; i < 3; i++) csel[i] = nx_q[i];
			2'd2:    for (int i = 0; i < 3; i++) csel[i] = ny_q[i];
			default: for (int i = 0; i < 3; i++) csel[i] = nz_q[i];
		endcase
	end

	logic signed [15:0] lsel, nsel;
	always_comb begin
		case (mterm_q)
			2'd0:    begin lsel = light_x_q; nsel = n_q[0]; end
			2'd1:    begin lsel = light_y_q; nsel = n_q[1]; end
			default: begin lsel = light_z_q; nsel = n_q[2]; end
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SETUP1: begin mul_a = acx_q; mul_b = 38'(aby_q); end
			S_SETUP2: begin mul_a = abx_q; mul_b = 38'(acy_q); end
			S_PIX0:   begin mul_a = apx_q; mul_b = 38'(acy_q); end
			S_PIX1:   begin mul_a = acx_q; mul_b = 38'(apy_q); end
			S_PIX2:   begin mul_a = abx_q; mul_b = 38'(apy_q); end
			S_PIX3:   begin mul_a = apx_q; mul_b = 38'(aby_q); end
			S_MIXM: begin
				mul_a = 18'(csel[term_q]);
				case (term_q)
					2'd0:    mul_b = na_q;
					2'd1:    mul_b = nb_q;
					default: mul_b = nc_q;
				endcase
			end
			S_DOT:    begin mul_a = 18'(nsel); mul_b = -38'(lsel); end
			default:  ;
		endcase
	end

	// restoring divider datapath, one quotient bit per cycle
	logic [56:0] rem_sh, dsub;
	logic [55:0] dabs;
	assign dabs   = 56'(d_q);
	assign rem_sh = {rem_q, quo_q[55]};
	assign dsub   = rem_sh - {1'b0, dabs};

	// coverage and index
	logic signed [37:0] nb_c;
	assign nb_c = neg_q ? -t1_q : t1_q;

	logic [7:0] shade_c;
	logic [43:0] dot255;
	assign dot255  = 44'(dot_q) * 44'd255;
	assign shade_c = (dot_q <= 0) ? 8'd0 :
		((dot255 >> 28) > 44'd255 ? 8'd255 : 8'(dot255 >> 28));

	logic [PIX_AW-1:0] pix_idx;
	assign pix_idx = PIX_AW'(py_q) * PIX_AW'(FRAME_WIDTH) + PIX_AW'(px_q);

	// bounding box in Q12.4 (clamped)
	localparam logic signed [16:0] XMAX = 17'((FRAME_WIDTH - 1) * 16);
	localparam logic signed [16:0] YMAX = 17'((FRAME_HEIGHT - 1) * 16);
	logic signed [16:0] lox, loy, hix, hiy;
	always_comb begin
		lox = XMAX; loy = YMAX; hix = '0; hiy = '0;
		for (int i = 0; i < 3; i++) begin
			if (17'(vx_q[i]) < lox) lox = 17'(vx_q[i]);
			if (17'(vy_q[i]) < loy) loy = 17'(vy_q[i]);
			if (17'(vx_q[i]) > hix) hix = 17'(vx_q[i]);
			if (17'(vy_q[i]) > hiy) hiy = 17'(vy_q[i]);
		end
		if (lox < 0) lox = '0;
		if (loy < 0) loy = '0;
		if (hix > XMAX) hix = XMAX;
		if (hiy > YMAX) hiy = YMAX;
		hix = hix + 17'sd15;
		hiy = hiy + 17'sd15;
	end

	assign busy = (state_q != S_IDLE);
	logic accept;
	assign accept = start && !busy;

	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = pix_idx;
		mem_wdepth = zval_q;
		mem_wshade = shade_c;
		mem_raddr  = pix_idx;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1; mem_waddr = clr_q; mem_wdepth = DEPTH_RST; mem_wshade = '0;
		end else if (state_q == S_SHADE) begin
			mem_we = 1'b1;
		end
		if (state_q == S_IDLE)
			mem_raddr = PIX_AW'(cmd.read_row) * PIX_AW'(FRAME_WIDTH) + PIX_AW'(cmd.read_col);
	end

	logic read_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			vcnt_q    <= '0;
			light_x_q <= LIGHT_X_RST;
			light_y_q <= LIGHT_Y_RST;
			light_z_q <= LIGHT_Z_RST;
			done      <= 1'b0;
			res       <= '0;
			count_q   <= '0;
		end else begin
			// strobe a word after a read, a finished triangle or a held vertex
			done <= (state_q == S_READ) || (state_q == S_FIN) ||
				(state_q == S_IDLE && accept && cmd.req_type == REQ_VERTEX &&
				vcnt_q != 2'd2);
			if (cfg_we) begin
				case (cfg_idx)
					REG_LIGHT_X: light_x_q <= cfg_data;
					REG_LIGHT_Y: light_y_q <= cfg_data;
					REG_LIGHT_Z: light_z_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PIX_AW'(NPIX - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						if (cmd.req_type == REQ_READ) begin
							// hold range flag, wait for the registered read
							read_ok_q <= (32'(cmd.read_col) < FRAME_WIDTH) &&
								(32'(cmd.read_row) < FRAME_HEIGHT);
							state_q <= S_READ;
						end else begin
							vx_q[vcnt_q] <= cmd.vert_x;
							vy_q[vcnt_q] <= cmd.vert_y;
							vz_q[vcnt_q] <= cmd.vert_depth;
							nx_q[vcnt_q] <= cmd.norm_x;
							ny_q[vcnt_q] <= cmd.norm_y;
							nz_q[vcnt_q] <= cmd.norm_z;
							if (vcnt_q == 2'd2) begin
								vcnt_q  <= '0;
								state_q <= S_SETUP0;
							end else begin
								vcnt_q <= vcnt_q + 1'b1;
								res    <= '0;
								state_q <= S_READ2;
							end
						end
					end
				end
				S_READ: begin
					res.pixel_shade    <= read_ok_q ? shade_rd_q : '0;
					res.pixel_depth    <= read_ok_q ? depth_rd_q : '0;
					res.triangle_done  <= 1'b0;
					res.pixels_written <= '0;
					state_q <= S_READ2;
				end
				S_READ2: state_q <= S_IDLE;
				S_SETUP0: begin
					abx_q <= 18'(vx_q[1]) - 18'(vx_q[0]);
					aby_q <= 18'(vy_q[1]) - 18'(vy_q[0]);
					acx_q <= 18'(vx_q[2]) - 18'(vx_q[0]);
					acy_q <= 18'(vy_q[2]) - 18'(vy_q[0]);
					count_q <= '0;
					state_q <= S_SETUP1;
				end
				S_SETUP1: begin
					d_q     <= 37'(mul_p);
					state_q <= S_SETUP2;
				end
				S_SETUP2: begin
					// hold |D| and its sign; drop degenerate triangles
					if ((d_q - 37'(mul_p)) > -37'sd256 && (d_q - 37'(mul_p)) < 37'sd256) begin
						state_q <= S_FIN;
					end else begin
						neg_q   <= (d_q - 37'(mul_p)) < 0;
						d_q     <= ((d_q - 37'(mul_p)) < 0) ?
							-(d_q - 37'(mul_p)) : (d_q - 37'(mul_p));
						state_q <= S_BOX;
					end
				end
				S_BOX: begin
					y0_q <= ROW_W'(loy >>> 4);
					x1_q <= COL_W'(hix >>> 4);
					y1_q <= ROW_W'(hiy >>> 4);
					px_q <= COL_W'(lox >>> 4);
					py_q <= ROW_W'(loy >>> 4);
					apx_q <= 18'(vx_q[0]) - 18'({1'b0, COL_W'(lox >>> 4), 4'b0});
					apy_q <= 18'(vy_q[0]) - 18'({1'b0, ROW_W'(loy >>> 4), 4'b0});
					state_q <= S_PIX0;
				end
				S_PIX0: begin t1_q <= 38'(mul_p); state_q <= S_PIX1; end
				S_PIX1: begin
					t1_q    <= t1_q - 38'(mul_p);
					state_q <= S_PIX2;
				end
				S_PIX2: begin
					nb_q    <= nb_c;
					t1_q    <= 38'(mul_p);
					state_q <= S_PIX3;
				end
				S_PIX3: begin
					// advance to mixing only for covered pixels
					nc_q <= neg_q ? -(t1_q - 38'(mul_p)) : (t1_q - 38'(mul_p));
					na_q <= 38'(d_q) - nb_q -
						(neg_q ? -(t1_q - 38'(mul_p)) : (t1_q - 38'(mul_p)));
					if (nb_q < 0 || (neg_q ? -(t1_q - 38'(mul_p)) : (t1_q - 38'(mul_p))) < 0 ||
						(38'(d_q) - nb_q - (neg_q ? -(t1_q - 38'(mul_p)) :
						(t1_q - 38'(mul_p)))) < 0) begin
						state_q <= S_NEXT;
					end else begin
						comp_q  <= '0;
						term_q  <= '0;
						acc_q   <= '0;
						state_q <= S_MIXM;
					end
				end
				S_MIXM: begin
					acc_q  <= acc_q + mul_p;
					term_q <= term_q + 1'b1;
					if (term_q == 2'd2) begin
						qneg_q <= (acc_q + mul_p) < 0;
						quo_q  <= ((acc_q + mul_p) < 0) ? 56'(-(acc_q + mul_p)) :
							56'(acc_q + mul_p);
						rem_q  <= '0;
						step_q <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (!dsub[56]) begin
						rem_q <= dsub[55:0];
						quo_q <= {quo_q[54:0], 1'b1};
					end else begin
						rem_q <= rem_sh[55:0];
						quo_q <= {quo_q[54:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (step_q == 6'd55) state_q <= S_DIVEND;
				end
				S_DIVEND: begin
					// floor: negative with remainder rounds one further down
					if (comp_q == 2'd0)
						zval_q <= qneg_q ? 16'(-$signed(quo_q) - ((rem_q != 0) ? 56'sd1 : 56'sd0))
							: 16'(quo_q);
					else
						n_q[comp_q - 2'd1] <= qneg_q ?
							16'(-$signed(quo_q) - ((rem_q != 0) ? 56'sd1 : 56'sd0)) : 16'(quo_q);
					if (comp_q == 2'd0) begin
						state_q <= S_ZTEST;
					end else if (comp_q == 2'd3) begin
						mterm_q <= '0;
						dot_q   <= '0;
						state_q <= S_DOT;
					end else begin
						comp_q <= comp_q + 1'b1;
						term_q <= '0;
						acc_q  <= '0;
						state_q <= S_MIXM;
					end
				end
				S_ZTEST: begin
					if (zval_q > depth_rd_q) begin
						comp_q <= 2'd1;
						term_q <= '0;
						acc_q  <= '0;
						state_q <= S_MIXM;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_DOT: begin
					dot_q   <= dot_q + 36'(mul_p);
					mterm_q <= mterm_q + 1'b1;
					if (mterm_q == 2'd2) state_q <= S_SHADE;
				end
				S_SHADE: begin
					if (count_q != COUNT_MAX) count_q <= count_q + 1'b1;
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					// walk columns outer, rows inner
					if (py_q != y1_q) begin
						py_q  <= py_q + 1'b1;
						apy_q <= apy_q - 18'sd16;
						state_q <= S_PIX0;
					end else if (px_q != x1_q) begin
						py_q  <= y0_q;
						apy_q <= 18'(vy_q[0]) - 18'({1'b0, y0_q, 4'b0});
						px_q  <= px_q + 1'b1;
						apx_q <= apx_q - 18'sd16;
						state_q <= S_PIX0;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					res.pixel_shade    <= '0;
					res.pixel_depth    <= '0;
					res.triangle_done  <= 1'b1;
					res.pixels_written <= count_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// no result while the clear sweep runs
	a_no_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !done) else $error("result during clear");
	// a read result never flags a finished triangle
	a_read_res: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) == S_READ |-> done && !res.triangle_done)
		else $error("read result malformed");
	// vertex counter never reaches three
	a_vcnt: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q != 2'd3) else $error("vertex count overflow");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking regression for zbuffer_triangle_shader_core
// Drives vertex and pixel-read words through the start/busy command port,
// keeps its own z-buffer and shade image, predicts every result word and
// checks each done strobe field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb;
	import zts_pkg::*;

	localparam int  MAX_CYCLES = 50_000_000;
	localparam int  ITEM_GOAL  = 600;

	typedef enum logic [1:0] {
		JOB_WORD,	// command word for the block
		JOB_CFG,	// register write, issued only while idle
		JOB_DRAIN,	// hold the sender until every result is back
		JOB_GAPS	// change the sender's idle rate
	} job_kind_e;

	typedef struct {
		job_kind_e   kind;
		cmd_word_t   word;
		logic [1:0]  idx;
		logic [15:0] data;
		int          pct;
	} job_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	cmd_word_t   cmd;
	logic        done;
	res_word_t   res;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [15:0] cfg_data;

	zbuffer_triangle_shader_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .res(res), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	// Stimulus still to be sent and result words still owed by the block.
	job_t      job_q[$];
	res_word_t owed_q[$];

	// Shadow of the block's state.
	logic signed [15:0] zbuf[NPIX];
	logic [7:0]         shade_img[NPIX];
	int                 vpos[3][3];	// x, y, depth per vertex
	int                 vnrm[3][3];
	int                 vtx_slot;
	int                 light[3];

	int  gap_pct;
	bit  took;
	int  cycles;
	int  errors;
	int  n_words, n_tris, n_reads, n_pixels, n_checked, n_cfg;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Floor division for a positive divisor.
	function automatic longint floor_div(longint num, longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q--;
		return q;
	endfunction

	// Rasterize the three held vertices into the shadow buffers and return
	// the number of pixels that won the depth test.
	function automatic int raster_triangle();
		longint ax, ay, abx, aby, acx, acy, d, sgn;
		longint apx, apy, wa, wb, wc, z, dot, s;
		longint nv[3];
		int lo_x, lo_y, hi_x, hi_y, x0, x1, y0, y1, idx, cnt;
		ax  = vpos[0][0];
		ay  = vpos[0][1];
		abx = vpos[1][0] - ax;
		aby = vpos[1][1] - ay;
		acx = vpos[2][0] - ax;
		acy = vpos[2][1] - ay;
		d   = acx * aby - abx * acy;
		sgn = 1;
		cnt = 0;
		// Skip slivers below one square pixel of doubled area.
		if (d > -256 && d < 256)
			return 0;
		if (d < 0) begin
			sgn = -1;
			d   = -d;
		end
		lo_x = (FRAME_WIDTH - 1) * 16;
		lo_y = (FRAME_HEIGHT - 1) * 16;
		hi_x = 0;
		hi_y = 0;
		for (int i = 0; i < 3; i++) begin
			if (vpos[i][0] < lo_x) lo_x = vpos[i][0];
			if (vpos[i][1] < lo_y) lo_y = vpos[i][1];
			if (vpos[i][0] > hi_x) hi_x = vpos[i][0];
			if (vpos[i][1] > hi_y) hi_y = vpos[i][1];
		end
		if (lo_x < 0) lo_x = 0;
		if (lo_y < 0) lo_y = 0;
		if (hi_x > (FRAME_WIDTH - 1) * 16) hi_x = (FRAME_WIDTH - 1) * 16;
		if (hi_y > (FRAME_HEIGHT - 1) * 16) hi_y = (FRAME_HEIGHT - 1) * 16;
		x0 = lo_x / 16;
		y0 = lo_y / 16;
		x1 = (hi_x + 15) / 16;
		y1 = (hi_y + 15) / 16;
		for (int px = x0; px <= x1; px++) begin
			for (int py = y0; py <= y1; py++) begin
				apx = ax - px * 16;
				apy = ay - py * 16;
				wb  = sgn * (apx * acy - acx * apy);
				wc  = sgn * (abx * apy - apx * aby);
				wa  = d - wb - wc;
				if (wa < 0 || wb < 0 || wc < 0)
					continue;
				z = floor_div(vpos[0][2] * wa + vpos[1][2] * wb + vpos[2][2] * wc, d);
				idx = py * FRAME_WIDTH + px;
				if (!(z > zbuf[idx]))
					continue;
				zbuf[idx] = z[15:0];
				for (int c = 0; c < 3; c++)
					nv[c] = floor_div(vnrm[0][c] * wa + vnrm[1][c] * wb
						+ vnrm[2][c] * wc, d);
				// Lambert term against the negated light, Q4.28.
				dot = -(nv[0] * light[0] + nv[1] * light[1] + nv[2] * light[2]);
				if (dot <= 0) begin
					shade_img[idx] = 8'd0;
				end else begin
					s = (dot * 255) >>> 28;
					shade_img[idx] = (s > 255) ? 8'd255 : s[7:0];
				end
				if (cnt < COUNT_MAX)
					cnt++;
			end
		end
		return cnt;
	endfunction

	// Work out the result word owed for one accepted command word.
	task automatic predict_word(input cmd_word_t w);
		res_word_t r;
		int        idx;
		r = '0;
		if (w.req_type == REQ_VERTEX) begin
			vpos[vtx_slot] = '{int'(w.vert_x), int'(w.vert_y), int'(w.vert_depth)};
			vnrm[vtx_slot] = '{int'(w.norm_x), int'(w.norm_y), int'(w.norm_z)};
			if (vtx_slot == 2) begin
				vtx_slot           = 0;
				r.triangle_done    = 1'b1;
				r.pixels_written   = 13'(raster_triangle());
				n_tris++;
				n_pixels += r.pixels_written;
			end else begin
				vtx_slot++;
			end
		end else begin
			// Every 6-bit address lies inside the 64x64 frame.
			idx           = int'(w.read_row) * FRAME_WIDTH + int'(w.read_col);
			r.pixel_shade = shade_img[idx];
			r.pixel_depth = zbuf[idx];
			n_reads++;
		end
		owed_q.insert(owed_q.size(), r);
	endtask

	// Append one job at the tail of the stimulus queue.
	task automatic add_job(input job_t j);
		job_q.insert(job_q.size(), j);
	endtask

	task automatic add_word(input cmd_word_t w);
		add_job('{JOB_WORD, w, 2'd0, 16'd0, 0});
		n_words++;
	endtask

	// Fill every field at random, so that ignored fields toggle too.
	function automatic cmd_word_t noise_word();
		logic [127:0] r;
		r = {$urandom, $urandom, $urandom, $urandom};
		return r[$bits(cmd_word_t)-1:0];
	endfunction

	task automatic add_vertex(input int x, input int y, input int z,
			input int nx, input int ny, input int nz);
		cmd_word_t w;
		w            = noise_word();
		w.req_type   = REQ_VERTEX;
		w.vert_x     = x[15:0];
		w.vert_y     = y[15:0];
		w.vert_depth = z[15:0];
		w.norm_x     = nx[15:0];
		w.norm_y     = ny[15:0];
		w.norm_z     = nz[15:0];
		add_word(w);
	endtask

	task automatic add_read(input int col, input int row);
		cmd_word_t w;
		w          = noise_word();
		w.req_type = REQ_READ;
		w.read_col = col[5:0];
		w.read_row = row[5:0];
		add_word(w);
	endtask

	task automatic add_lights(input int lx, input int ly, input int lz);
		add_job('{JOB_DRAIN, '0, 2'd0, 16'd0, 0});
		add_job('{JOB_CFG, '0, REG_LIGHT_X, lx[15:0], 0});
		add_job('{JOB_CFG, '0, REG_LIGHT_Y, ly[15:0], 0});
		add_job('{JOB_CFG, '0, REG_LIGHT_Z, lz[15:0], 0});
	endtask

	task automatic add_gaps(input int pct);
		add_job('{JOB_GAPS, '0, 2'd0, 16'd0, pct});
	endtask

	// One random triangle: mostly a few pixels across inside the frame,
	// now and then spread over the whole 16-bit coordinate range.
	task automatic add_random_triangle();
		int cx, cy, span;
		bit wide;
		wide = ($urandom_range(0, 99) < 2);
		cx   = $urandom_range(0, FRAME_WIDTH * 16 - 1);
		cy   = $urandom_range(0, FRAME_HEIGHT * 16 - 1);
		span = $urandom_range(8, 120);
		for (int v = 0; v < 3; v++) begin
			if (wide)
				add_vertex($signed(16'($urandom)), $signed(16'($urandom)),
					$signed(16'($urandom)), $signed(16'($urandom)),
					$signed(16'($urandom)), $signed(16'($urandom)));
			else
				add_vertex(cx + $urandom_range(0, 2 * span) - span,
					cy + $urandom_range(0, 2 * span) - span,
					$signed(16'($urandom)), $signed(16'($urandom)),
					$signed(16'($urandom)), $signed(16'($urandom)));
			// Slip a read between vertices now and then.
			if (v < 2 && $urandom_range(0, 9) == 0)
				add_read($urandom_range(0, 63), $urandom_range(0, 63));
		end
	endtask

	task automatic add_random_phase(input int goal);
		while (n_words < goal) begin
			if ($urandom_range(0, 99) < 70)
				add_random_triangle();
			else
				add_read($urandom_range(0, 63), $urandom_range(0, 63));
		end
	endtask

	// Build the whole run up front.
	initial begin
		for (int i = 0; i < NPIX; i++) begin
			zbuf[i]      = DEPTH_RST;
			shade_img[i] = 8'd0;
		end
		vtx_slot = 0;
		light    = '{int'(LIGHT_X_RST), int'(LIGHT_Y_RST), int'(LIGHT_Z_RST)};
		gap_pct  = 0;

		// Directed part under the reset light.
		add_read(0, 0);
		add_read(63, 63);
		// Small counter-clockwise triangle.
		add_vertex(160, 160, 4096, 0, 0, 16384);
		add_vertex(320, 160, 4096, 16384, 0, 0);
		add_read(12, 12);
		add_vertex(160, 320, 4096, 0, 16384, 16384);
		add_read(12, 12);
		// Same triangle wound the other way at equal depth: nothing wins.
		add_vertex(160, 160, 4096, 0, 0, 16384);
		add_vertex(160, 320, 4096, 0, 0, 16384);
		add_vertex(320, 160, 4096, 0, 0, 16384);
		// Collinear vertices: degenerate, nothing drawn.
		add_vertex(0, 0, 100, 0, 0, 0);
		add_vertex(160, 160, 100, 0, 0, 0);
		add_vertex(480, 480, 100, 0, 0, 0);
		// Fully off-frame: only the corner pixel (0, 0) gets probed.
		add_vertex(-32768, -32768, 0, 0, 0, 0);
		add_vertex(-1000, -32768, 0, 0, 0, 0);
		add_vertex(-32768, -1000, 0, 0, 0, 0);
		// Field extremes; the frame lies just past the long edge.
		add_vertex(-32768, -32768, 32767, 32767, -32768, 32767);
		add_vertex(32767, -32768, -32768, -32768, 32767, -32768);
		add_vertex(-32768, 32767, 32767, 32767, 32767, 32767);
		add_read(63, 0);
		add_read(0, 63);
		add_read(20, 20);

		// Random part in four phases under three idle rates and lights.
		add_lights(-32768, -32768, -32768);
		add_gaps(29);
		add_random_phase(ITEM_GOAL / 3);
		add_job('{JOB_DRAIN, '0, 2'd0, 16'd0, 0});
		add_random_phase(ITEM_GOAL / 2);
		add_lights(32767, 32767, 32767);
		add_gaps(71);
		add_random_phase(2 * ITEM_GOAL / 3);
		add_lights($signed(16'($urandom)), $signed(16'($urandom)),
			$signed(16'($urandom)));
		add_gaps(0);
		add_random_phase(ITEM_GOAL);
	end

	// Reset once, then release at a falling edge.
	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		start    = 1'b0;
		cmd      = '0;
		cfg_we   = 1'b0;
		cfg_idx  = REG_LIGHT_X;
		cfg_data = '0;
	end

	// Sampling side: note handshakes, predict accepted words, check results.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			took <= 1'b0;
		end else begin
			took <= start && !busy;
			if (start && !busy)
				predict_word(cmd);
			if (cfg_we) begin
				light[cfg_idx] = int'($signed(cfg_data));
				n_cfg++;
			end
			if (done) begin
				if (owed_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("[%0t] unexpected result word %p", $time, res);
				end else begin
					res_word_t want;
					want = owed_q.pop_front();
					n_checked++;
					if (res.pixel_shade !== want.pixel_shade
							|| res.pixel_depth !== want.pixel_depth
							|| res.triangle_done !== want.triangle_done
							|| res.pixels_written !== want.pixels_written) begin
						errors++;
						if (errors <= 10)
							$display("[%0t] mismatch: expected %p, got %p",
								$time, want, res);
					end
				end
			end
		end
	end

	// Sending side: advance on the falling edge, hold a word until taken.
	always @(negedge clk) begin
		logic go, wr;
		go = 1'b0;
		wr = 1'b0;
		if (arst_n && !(start && !took)) begin
			while (job_q.size() > 0 && job_q[0].kind == JOB_GAPS)
				gap_pct = job_q.pop_front().pct;
			if (job_q.size() > 0) begin
				case (job_q[0].kind)
					JOB_DRAIN: begin
						if (owed_q.size() == 0 && !busy)
							void'(job_q.pop_front());
					end
					JOB_CFG: begin
						if (owed_q.size() == 0 && !busy && !cfg_we) begin
							cfg_idx  <= job_q[0].idx;
							cfg_data <= job_q[0].data;
							wr = 1'b1;
							void'(job_q.pop_front());
						end
					end
					default: begin
						if ($urandom_range(0, 99) >= gap_pct) begin
							cmd <= job_q.pop_front().word;
							go = 1'b1;
						end
					end
				endcase
			end
		end
		// Keep start up while a word waits for acceptance.
		start  <= (start && !took && arst_n) || go;
		cfg_we <= wr;
	end

	// Wind down once all stimulus is in and every result has come back.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (job_q.size() == 0 && !start && owed_q.size() == 0)
				break;
		end
		repeat (200) @(posedge clk);
		$display("covered %0d words: %0d triangles drawing %0d pixels, %0d reads",
			n_words, n_tris, n_pixels, n_reads);
		$display("%0d results checked, %0d register writes, %0d errors",
			n_checked, n_cfg, errors);
		if (errors == 0)
			$display("zbuffer_triangle_shader_core regression: pass");
		else
			$display("zbuffer_triangle_shader_core regression: fail");
		$finish;
	end

	// Watchdog.
	initial begin
		cycles = 0;
		while (cycles < MAX_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("zbuffer_triangle_shader_core regression: fail");
		$finish;
	end

endmodule

[sim.f]
rtl/zts_pkg.sv
rtl/zbuffer_triangle_shader_core.sv
dv/tb.sv
